// ===== rtl/ppi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types and codes for the three-port parallel interface.
// ----------------------------------------------------------------------------
package ppi_pkg;

    // item kinds
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_STB   = 2'd2;
    localparam logic [1:0] OP_ACK   = 2'd3;

    // register select
    localparam logic [1:0] OFF_A    = 2'd0;
    localparam logic [1:0] OFF_B    = 2'd1;
    localparam logic [1:0] OFF_C    = 2'd2;
    localparam logic [1:0] OFF_CTRL = 2'd3;

    // group A modes
    localparam logic [1:0] MODE_0   = 2'd0;
    localparam logic [1:0] MODE_1   = 2'd1;
    localparam logic [1:0] MODE_2   = 2'd2;
    localparam logic [1:0] MODE_2B  = 2'd3;  // alias code, folded into mode 2

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] offset;
        logic [7:0] wdata;
        logic [7:0] pins_a;
        logic [7:0] pins_b;
        logic [7:0] pins_c;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] port_a_out;
        logic [7:0] port_b_out;
        logic [7:0] port_c_out;
        logic       port_a_strobe;
        logic       port_b_strobe;
        logic       port_c_strobe;
        logic       obf_pin;
        logic       ibf_pin;
        logic       intr_pin;
    } t_out_item;

endpackage
`default_nettype wire

// ===== rtl/ppi_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_in_if
// Valid/ready channel carrying one bus or handshake item.
// ----------------------------------------------------------------------------
interface ppi_in_if;
    logic              valid;
    logic              ready;
    ppi_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ppi_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_out_if
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface ppi_out_if;
    logic               valid;
    logic               ready;
    ppi_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/parallel_port_interface_8255_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// parallel_port_interface_8255_top
// Three-port parallel interface with mode 0 ports and a port A mode 2
// handshake driving OBF, IBF and INTR.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    opcode, offset, wdata, pins_a/b/c
//  o_res    out  valid/ready    read_data, port drives, strobes, OBF/IBF/INTR
//
//  The state update and the result are computed from the accepted item and
//  the state registers and land in the result register.
//  A new item is taken every cycle while the result register is empty or
//  being taken; a stalled result blocks input only until it is consumed.
//  Synchronous active-low reset puts the ports in mode 0, all input.
// ----------------------------------------------------------------------------
module parallel_port_interface_8255_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ppi_in_if.sink    i_in,
    ppi_out_if.source o_res
);
    import ppi_pkg::*;

    // state
    logic [1:0] r_mode_a, n_mode_a;
    logic       r_mode_b, n_mode_b;
    logic [7:0] r_dir_a, n_dir_a, r_dir_b, n_dir_b, r_dir_c, n_dir_c;
    logic [7:0] r_lat_a, n_lat_a, r_lat_b, n_lat_b, r_lat_c, n_lat_c;
    logic [1:0] r_int_en, n_int_en;
    logic [7:0] r_drv_a, n_drv_a, r_drv_b, n_drv_b, r_drv_c, n_drv_c;
    logic       r_obf, n_obf, r_ibf, n_ibf, r_intr, n_intr;

    // result stage
    logic       r_out_valid;
    t_out_item  r_out, n_out;

    logic       w_accept;
    logic [7:0] w_rd;
    logic       w_sa, w_sb, w_sc;
    logic [7:0] w_bit_mask;
    logic [7:0] w_bsr;
    logic [1:0] w_new_mode_a;
    t_in_item   w_it;

    // latch merged with direction: output bits from the latch, input bits high
    function automatic logic [7:0] merged(input logic [7:0] lat, input logic [7:0] dir);
        merged = (lat & ~dir) | dir;
    endfunction

    // interrupt request from port C latch and enables
    function automatic logic intr_of(input logic [7:0] lat_c, input logic [1:0] en);
        intr_of = ((lat_c[5:4] == 2'b11) && en[0]) || ((lat_c[7:6] == 2'b11) && en[1]);
    endfunction

    assign w_it       = i_in.data;
    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_res.ready;
    assign w_bit_mask = 8'h01 << w_it.wdata[3:1];
    assign w_bsr      = w_it.wdata[0] ? (r_lat_c | w_bit_mask) : (r_lat_c & ~w_bit_mask);
    assign w_new_mode_a = (w_it.wdata[6:5] == MODE_2B) ? MODE_2 : w_it.wdata[6:5];

    // next state and result for the incoming item
    always_comb begin
        n_mode_a = r_mode_a;  n_mode_b = r_mode_b;
        n_dir_a  = r_dir_a;   n_dir_b  = r_dir_b;   n_dir_c = r_dir_c;
        n_lat_a  = r_lat_a;   n_lat_b  = r_lat_b;   n_lat_c = r_lat_c;
        n_int_en = r_int_en;
        n_drv_a  = r_drv_a;   n_drv_b  = r_drv_b;   n_drv_c = r_drv_c;
        n_obf    = r_obf;     n_ibf    = r_ibf;     n_intr  = r_intr;
        w_rd = 8'h00;
        w_sa = 1'b0;  w_sb = 1'b0;  w_sc = 1'b0;

        unique case (w_it.opcode)
            OP_READ: begin
                unique case (w_it.offset)
                    OFF_A: begin
                        if (r_mode_a == MODE_0) begin
                            w_rd = (r_dir_a == 8'h00) ? r_lat_a : w_it.pins_a;
                        end else if (r_mode_a == MODE_2) begin
                            w_rd = r_lat_a;
                            // reading the buffer clears IBF
                            n_ibf = 1'b0;
                            n_lat_c[5] = 1'b0;
                            n_intr = intr_of(n_lat_c, r_int_en);
                            n_lat_c[3] = n_intr;
                        end else begin
                            w_rd = 8'hFF;
                        end
                    end
                    OFF_B: w_rd = (r_dir_b == 8'h00) ? r_lat_b : w_it.pins_b;
                    OFF_C: begin
                        if (r_mode_a == MODE_0) begin
                            w_rd = (r_lat_c & ~r_dir_c) | (w_it.pins_c & r_dir_c);
                        end else if (r_mode_a == MODE_2) begin
                            w_rd = (r_lat_c & 8'hA8)
                                 | {1'b0, r_int_en[1], 1'b0, r_int_en[0], 4'h0}
                                 | (r_lat_c & ~r_dir_c & 8'h07)
                                 | (w_it.pins_c & r_dir_c & 8'h07);
                        end else begin
                            w_rd = 8'hFF;
                        end
                    end
                    OFF_CTRL: w_rd = 8'hFF;
                endcase
            end
            OP_WRITE: begin
                unique case (w_it.offset)
                    OFF_A: begin
                        n_lat_a = w_it.wdata;
                        if (r_mode_a == MODE_0) begin
                            n_drv_a = merged(w_it.wdata, r_dir_a);
                            w_sa = 1'b1;
                        end else if (r_mode_a == MODE_2) begin
                            n_drv_a = w_it.wdata;
                            w_sa = 1'b1;
                            n_obf = 1'b0;
                            n_lat_c[7] = 1'b0;
                            n_intr = intr_of(n_lat_c, r_int_en);
                            n_lat_c[3] = n_intr;
                        end
                    end
                    OFF_B: begin
                        n_lat_b = w_it.wdata;
                        n_drv_b = merged(w_it.wdata, r_dir_b);
                        w_sb = 1'b1;
                    end
                    OFF_C: begin
                        if (r_mode_a == MODE_0) begin
                            n_lat_c = w_it.wdata;
                            n_drv_c = merged(n_lat_c, r_dir_c);
                            w_sc = 1'b1;
                        end else if (r_mode_a == MODE_2) begin
                            // handshake bits are read-only here: OR into low bits
                            n_lat_c = r_lat_c | (w_it.wdata & 8'h07);
                            n_drv_c = merged(n_lat_c, r_dir_c);
                            w_sc = 1'b1;
                        end
                    end
                    OFF_CTRL: begin
                        if (w_it.wdata[7]) begin
                            // mode set
                            n_mode_a = w_new_mode_a;
                            n_mode_b = w_it.wdata[2];
                            if (w_new_mode_a != MODE_1 && !w_it.wdata[2]) begin
                                n_dir_a = {8{w_it.wdata[4]}};
                                n_dir_b = {8{w_it.wdata[1]}};
                                n_dir_c = {{4{w_it.wdata[3]}}, {4{w_it.wdata[0]}}};
                                n_lat_a = 8'h00;
                                n_lat_b = 8'h00;
                                n_lat_c = 8'h00;
                                n_drv_a = n_dir_a;
                                n_drv_b = n_dir_b;
                                w_sa = 1'b1;
                                w_sb = 1'b1;
                                if (w_new_mode_a == MODE_0) begin
                                    n_drv_c = n_dir_c;
                                    w_sc = 1'b1;
                                end else begin
                                    n_int_en = 2'b00;
                                    n_obf = 1'b0;
                                    n_ibf = 1'b0;
                                    n_intr = 1'b0;
                                end
                            end
                        end else if (r_mode_a == MODE_2) begin
                            // bit set/reset in mode 2: enables follow bits 6 and 4,
                            // INTR is judged on the latch before this write
                            n_int_en = {w_bsr[6], w_bsr[4]};
                            n_intr = intr_of(r_lat_c, n_int_en);
                            n_lat_c = (r_lat_c & 8'h50) | (w_bsr & 8'hAF);
                        end else begin
                            n_lat_c = w_bsr;
                        end
                    end
                endcase
            end
            OP_STB: begin
                if (r_mode_a == MODE_2) begin
                    n_lat_c[4] = (w_it.wdata != 8'h00);
                    if (w_it.wdata == 8'h00) begin
                        n_lat_a = w_it.pins_a;
                        n_ibf = 1'b1;
                        n_lat_c[5] = 1'b1;
                    end
                    n_intr = intr_of(n_lat_c, r_int_en);
                    n_lat_c[3] = n_intr;
                end
            end
            OP_ACK: begin
                if (r_mode_a == MODE_2) begin
                    n_lat_c[6] = (w_it.wdata != 8'h00);
                    if (w_it.wdata == 8'h00) begin
                        n_obf = 1'b1;
                        n_lat_c[7] = 1'b1;
                    end
                    n_intr = intr_of(n_lat_c, r_int_en);
                    n_lat_c[3] = n_intr;
                end
            end
        endcase

        n_out.read_data     = w_rd;
        n_out.port_a_out    = n_drv_a;
        n_out.port_b_out    = n_drv_b;
        n_out.port_c_out    = n_drv_c;
        n_out.port_a_strobe = w_sa;
        n_out.port_b_strobe = w_sb;
        n_out.port_c_strobe = w_sc;
        n_out.obf_pin       = n_obf;
        n_out.ibf_pin       = n_ibf;
        n_out.intr_pin      = n_intr;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_a <= MODE_0;
            r_mode_b <= 1'b0;
            r_dir_a  <= 8'hFF;
            r_dir_b  <= 8'hFF;
            r_dir_c  <= 8'hFF;
            r_lat_a  <= 8'h00;
            r_lat_b  <= 8'h00;
            r_lat_c  <= 8'h00;
            r_int_en <= 2'b00;
            r_drv_a  <= 8'hFF;
            r_drv_b  <= 8'hFF;
            r_drv_c  <= 8'hFF;
            r_obf    <= 1'b0;
            r_ibf    <= 1'b0;
            r_intr   <= 1'b0;
        end else if (w_accept) begin
            r_mode_a <= n_mode_a;
            r_mode_b <= n_mode_b;
            r_dir_a  <= n_dir_a;
            r_dir_b  <= n_dir_b;
            r_dir_c  <= n_dir_c;
            r_lat_a  <= n_lat_a;
            r_lat_b  <= n_lat_b;
            r_lat_c  <= n_lat_c;
            r_int_en <= n_int_en;
            r_drv_a  <= n_drv_a;
            r_drv_b  <= n_drv_b;
            r_drv_c  <= n_drv_c;
            r_obf    <= n_obf;
            r_ibf    <= n_ibf;
            r_intr   <= n_intr;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // group B mode is kept for the mode word but steers nothing else
    logic w_mode_b_unused;
    assign w_mode_b_unused = r_mode_b;

endmodule
`default_nettype wire

// ===== dv/parallel_port_interface_8255_top_tb.sv =====
// ----------------------------------------------------------------------------
// parallel_port_interface_8255_top_tb
// Self-checking bench for the three-port parallel interface. Items are sent
// on the input channel and each is run through a behavioral copy of the port
// logic: modes, directions, latches, port C bit set/reset and the port A
// mode-2 strobe/acknowledge handshake. Every result item is compared, field
// by field, against the oldest prediction. A directed pass is followed by
// mode-aware random traffic under three idle/stall profiles.
// ----------------------------------------------------------------------------
module parallel_port_interface_8255_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppi_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_HOLD  = 8;

    // port C bit positions used by the mode-2 handshake
    localparam int PC_OBF_BIT  = 7;
    localparam int PC_ACK_BIT  = 6;
    localparam int PC_IBF_BIT  = 5;
    localparam int PC_STB_BIT  = 4;
    localparam int PC_INTR_BIT = 3;

    logic i_clk;
    logic i_rst_n;

    ppi_in_if  in_ch ();
    ppi_out_if res_ch ();

    parallel_port_interface_8255_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_res  (res_ch)
    );

    // predicted port state
    logic [1:0] m_grp_a;
    logic       m_grp_b;
    logic [7:0] m_dir_a, m_dir_b, m_dir_c;
    logic [7:0] m_lat_a, m_lat_b, m_lat_c;
    logic [7:0] m_drv_a, m_drv_b, m_drv_c;
    logic [1:0] m_int_en;
    logic       m_obf, m_ibf, m_intr;

    t_out_item port_result_q[$];
    t_out_item mon_want, mon_got;

    int src_idle_pct;
    int snk_idle_pct;
    int item_cnt;
    int op_cnt[4];
    int checked_cnt;
    int mismatch_cnt;
    int cycle_cnt;
    int mode0_cnt, mode2_cnt, odd_mode_cnt;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void pc_update_intr();
        logic in_req, out_req;
        in_req  = m_lat_c[PC_IBF_BIT] && m_lat_c[PC_STB_BIT] && m_int_en[0];
        out_req = m_lat_c[PC_OBF_BIT] && m_lat_c[PC_ACK_BIT] && m_int_en[1];
        m_intr  = in_req | out_req;
        m_lat_c[PC_INTR_BIT] = m_intr;
    endfunction

    function automatic void pc_set_obf(input logic v);
        m_lat_c[PC_OBF_BIT] = v;
        m_obf = v;
    endfunction

    function automatic void pc_set_ibf(input logic v);
        m_lat_c[PC_IBF_BIT] = v;
        m_ibf = v;
    endfunction

    function automatic t_out_item predict_port_result(input t_in_item it);
        t_out_item  r;
        logic [7:0] d;
        logic [7:0] nv;
        logic [1:0] gm;
        logic       high;
        r = '0;
        d = it.wdata;
        case (it.opcode)
            OP_READ: begin
                case (it.offset)
                    OFF_A: begin
                        if (m_grp_a == MODE_0) begin
                            r.read_data = (m_dir_a == 8'h00) ? m_lat_a : it.pins_a;
                        end else if (m_grp_a == MODE_2) begin
                            // reading the input buffer empties it
                            r.read_data = m_lat_a;
                            pc_set_ibf(1'b0);
                            pc_update_intr();
                        end else begin
                            r.read_data = 8'hFF;
                        end
                    end
                    OFF_B: r.read_data = (m_dir_b == 8'h00) ? m_lat_b : it.pins_b;
                    OFF_C: begin
                        if (m_grp_a == MODE_0) begin
                            r.read_data = (m_lat_c & ~m_dir_c) | (it.pins_c & m_dir_c);
                        end else if (m_grp_a == MODE_2) begin
                            // status bits from the latch, enables in place of ACK/STB
                            r.read_data = (m_lat_c & 8'hA8)
                                        | {1'b0, m_int_en[1], 1'b0, m_int_en[0], 4'b0}
                                        | (((m_lat_c & ~m_dir_c) | (it.pins_c & m_dir_c))
                                           & 8'h07);
                        end else begin
                            r.read_data = 8'hFF;
                        end
                    end
                    default: r.read_data = 8'hFF;
                endcase
            end
            OP_WRITE: begin
                case (it.offset)
                    OFF_A: begin
                        m_lat_a = d;
                        if (m_grp_a == MODE_0) begin
                            m_drv_a = m_lat_a | m_dir_a;
                            r.port_a_strobe = 1'b1;
                        end else if (m_grp_a == MODE_2) begin
                            m_drv_a = m_lat_a;
                            r.port_a_strobe = 1'b1;
                            pc_set_obf(1'b0);
                            pc_update_intr();
                        end
                    end
                    OFF_B: begin
                        m_lat_b = d;
                        m_drv_b = m_lat_b | m_dir_b;
                        r.port_b_strobe = 1'b1;
                    end
                    OFF_C: begin
                        if (m_grp_a != MODE_1) begin
                            // mode 2 can only set the low three bits
                            m_lat_c = (m_grp_a == MODE_0) ? d : (m_lat_c | (d & 8'h07));
                            m_drv_c = m_lat_c | m_dir_c;
                            r.port_c_strobe = 1'b1;
                        end
                    end
                    default: begin
                        if (d[7]) begin
                            // mode word
                            gm = d[6:5];
                            if (gm == MODE_2B) gm = MODE_2;
                            m_grp_a = gm;
                            m_grp_b = d[2];
                            if (gm == MODE_1 || d[2]) begin
                                odd_mode_cnt++;
                            end else begin
                                if (gm == MODE_0) mode0_cnt++;
                                else mode2_cnt++;
                                m_dir_a = d[4] ? 8'hFF : 8'h00;
                                m_dir_b = d[1] ? 8'hFF : 8'h00;
                                m_dir_c = {d[3] ? 4'hF : 4'h0, d[0] ? 4'hF : 4'h0};
                                m_lat_a = 8'h00;
                                m_lat_b = 8'h00;
                                m_lat_c = 8'h00;
                                m_drv_a = m_dir_a;
                                m_drv_b = m_dir_b;
                                r.port_a_strobe = 1'b1;
                                r.port_b_strobe = 1'b1;
                                if (gm == MODE_0) begin
                                    m_drv_c = m_dir_c;
                                    r.port_c_strobe = 1'b1;
                                end else begin
                                    m_int_en = 2'b00;
                                    pc_set_obf(1'b0);
                                    pc_set_ibf(1'b0);
                                    pc_update_intr();
                                end
                            end
                        end else begin
                            // port C bit set/reset
                            nv = m_lat_c;
                            nv[d[3:1]] = d[0];
                            if (m_grp_a == MODE_2) begin
                                // enables follow bits 6/4; INTR sees the old latch
                                m_int_en = {nv[PC_ACK_BIT], nv[PC_STB_BIT]};
                                nv = (m_lat_c & 8'h50) | (nv & 8'hAF);
                                pc_update_intr();
                            end
                            m_lat_c = nv;
                        end
                    end
                endcase
            end
            default: begin
                // strobe / acknowledge levels only matter in mode 2
                if (m_grp_a == MODE_2) begin
                    high = (d != 8'h00);
                    if (it.opcode == OP_STB) begin
                        m_lat_c[PC_STB_BIT] = high;
                        if (!high) begin
                            m_lat_a = it.pins_a;
                            pc_set_ibf(1'b1);
                        end
                    end else begin
                        m_lat_c[PC_ACK_BIT] = high;
                        if (!high) pc_set_obf(1'b1);
                    end
                    pc_update_intr();
                end
            end
        endcase
        r.port_a_out = m_drv_a;
        r.port_b_out = m_drv_b;
        r.port_c_out = m_drv_c;
        r.obf_pin    = m_obf;
        r.ibf_pin    = m_ibf;
        r.intr_pin   = m_intr;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    // line level for strobe/ack: half low, half some nonzero byte
    function automatic logic [7:0] rand_level();
        return $urandom_range(1) ? 8'($urandom_range(255, 1)) : 8'h00;
    endfunction

    // send one item, idling at random first; predict it once accepted
    task automatic send_item(input logic [1:0] op, input logic [1:0] off,
                             input logic [7:0] d, input logic [7:0] pa,
                             input logic [7:0] pb, input logic [7:0] pc);
        t_in_item it;
        it.opcode = op;
        it.offset = off;
        it.wdata  = d;
        it.pins_a = pa;
        it.pins_b = pb;
        it.pins_c = pc;
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        port_result_q.push_back(predict_port_result(it));
        item_cnt++;
        op_cnt[op]++;
    endtask

    task automatic send_rand_pins(input logic [1:0] op, input logic [1:0] off,
                                  input logic [7:0] d);
        send_item(op, off, d, rand_byte(), rand_byte(), rand_byte());
    endtask

    // hold off the sender until every outstanding result is back
    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (port_result_q.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_state();
        send_item(OP_READ, OFF_A, 8'h00, 8'hFF, 8'h00, 8'h00);
        send_item(OP_READ, OFF_CTRL, 8'hFF, 8'h00, 8'hFF, 8'hFF);
    endtask

    task automatic test_mode0_ports();
        send_item(OP_WRITE, OFF_CTRL, 8'h80, 8'h00, 8'h00, 8'h00);  // all output
        send_item(OP_WRITE, OFF_A, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_item(OP_WRITE, OFF_C, 8'hA5, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ, OFF_C, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_item(OP_WRITE, OFF_CTRL, 8'h9B, 8'h00, 8'h00, 8'h00);  // all input
        send_item(OP_READ, OFF_A, 8'h00, 8'h5A, 8'hFF, 8'h00);
        send_item(OP_WRITE, OFF_CTRL, 8'h88, 8'h00, 8'h00, 8'h00);  // C upper in
        send_item(OP_READ, OFF_C, 8'h00, 8'h00, 8'h00, 8'h3C);
        send_item(OP_WRITE, OFF_CTRL, 8'h0F, 8'h00, 8'h00, 8'h00);  // set C bit 7
        send_item(OP_WRITE, OFF_CTRL, 8'h00, 8'h00, 8'h00, 8'h00);  // clear C bit 0
        send_item(OP_STB, OFF_A, 8'h00, 8'hFF, 8'h00, 8'h00);       // ignored here
    endtask

    task automatic test_mode2_handshake();
        send_item(OP_WRITE, OFF_CTRL, 8'hC0, 8'h00, 8'h00, 8'h00);
        send_item(OP_WRITE, OFF_CTRL, 8'h0D, 8'h00, 8'h00, 8'h00);  // ACK enable
        send_item(OP_WRITE, OFF_CTRL, 8'h09, 8'h00, 8'h00, 8'h00);  // STB enable
        send_item(OP_STB, OFF_A, 8'h00, 8'hC3, 8'h00, 8'h00);       // latch input
        send_item(OP_STB, OFF_A, 8'h01, 8'h00, 8'h00, 8'h00);       // INTR rises
        send_item(OP_READ, OFF_C, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_item(OP_READ, OFF_A, 8'h00, 8'h00, 8'h00, 8'h00);      // IBF clears
        send_item(OP_WRITE, OFF_A, 8'h77, 8'h00, 8'h00, 8'h00);
        send_item(OP_ACK, OFF_A, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_ACK, OFF_A, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_item(OP_WRITE, OFF_C, 8'hFF, 8'h00, 8'h00, 8'h00);     // only sets low bits
        send_item(OP_WRITE, OFF_CTRL, 8'hE0, 8'h00, 8'h00, 8'h00);  // code 3 as mode 2
    endtask

    task automatic test_unsupported_modes();
        send_item(OP_WRITE, OFF_CTRL, 8'hA0, 8'h00, 8'h00, 8'h00);  // group A mode 1
        send_item(OP_READ, OFF_C, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_WRITE, OFF_C, 8'h5A, 8'h00, 8'h00, 8'h00);
        send_item(OP_WRITE, OFF_CTRL, 8'h84, 8'h00, 8'h00, 8'h00);  // group B mode 1
        send_item(OP_READ, OFF_B, 8'h00, 8'h00, 8'hA5, 8'h00);
    endtask

    // mode words followed by bursts of accesses that mostly suit the current mode, with random noise items
    task automatic test_random_traffic(input int n_items);
        int         stop_at;
        int         pick;
        logic [7:0] d;
        stop_at = item_cnt + n_items;
        while (item_cnt < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 45) d = 8'h80 | (rand_byte() & 8'h1B);
            else if (pick < 80) d = ($urandom_range(1) ? 8'hC0 : 8'hE0) | (rand_byte() & 8'h1B);
            else d = 8'h80 | 8'($urandom_range(127));
            send_rand_pins(OP_WRITE, OFF_CTRL, d);
            repeat ($urandom_range(40, 10)) begin
                if ($urandom_range(99) < 8) begin
                    // noise: anything at all
                    send_rand_pins(2'($urandom_range(3)), 2'($urandom_range(3)), rand_level());
                end else if (m_grp_a == MODE_2) begin
                    case ($urandom_range(9))
                        0, 1: begin
                            send_rand_pins(OP_STB, OFF_A, 8'h00);
                            send_rand_pins(OP_STB, OFF_A, 8'($urandom_range(255, 1)));
                            if ($urandom_range(1)) send_rand_pins(OP_READ, OFF_A, rand_byte());
                        end
                        2, 3: begin
                            send_rand_pins(OP_WRITE, OFF_A, rand_byte());
                            send_rand_pins(OP_ACK, OFF_A, 8'h00);
                            send_rand_pins(OP_ACK, OFF_A, 8'($urandom_range(255, 1)));
                        end
                        4: send_rand_pins(OP_WRITE, OFF_CTRL,
                                          {4'b0, ($urandom_range(1) ? 3'd6 : 3'd4),
                                           1'($urandom_range(1))});
                        5: send_rand_pins(OP_WRITE, OFF_CTRL, 8'($urandom_range(15)));
                        6: send_rand_pins(OP_READ, OFF_C, rand_byte());
                        7: send_rand_pins(OP_READ, OFF_A, rand_byte());
                        8: send_rand_pins(OP_WRITE, OFF_C, rand_byte());
                        default: send_rand_pins($urandom_range(1) ? OP_READ : OP_WRITE,
                                                OFF_B, rand_byte());
                    endcase
                end else begin
                    case ($urandom_range(9))
                        0, 1, 2, 3: send_rand_pins(OP_READ, 2'($urandom_range(3)), rand_byte());
                        4, 5, 6, 7: send_rand_pins(OP_WRITE, 2'($urandom_range(2)), rand_byte());
                        default: send_rand_pins(OP_WRITE, OFF_CTRL, 8'($urandom_range(15)));
                    endcase
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    function automatic void check_field(input string fname, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            mismatch_cnt++;
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, fname, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            mon_got = res_ch.data;
            if (port_result_q.size() == 0) begin
                mismatch_cnt++;
                $display("%0t: unexpected result item, expected none, actual %h",
                         $time, mon_got);
            end else begin
                mon_want = port_result_q.pop_front();
                checked_cnt++;
                check_field("read_data", mon_want.read_data, mon_got.read_data);
                check_field("port_a_out", mon_want.port_a_out, mon_got.port_a_out);
                check_field("port_b_out", mon_want.port_b_out, mon_got.port_b_out);
                check_field("port_c_out", mon_want.port_c_out, mon_got.port_c_out);
                check_field("port_a_strobe", 8'(mon_want.port_a_strobe),
                            8'(mon_got.port_a_strobe));
                check_field("port_b_strobe", 8'(mon_want.port_b_strobe),
                            8'(mon_got.port_b_strobe));
                check_field("port_c_strobe", 8'(mon_want.port_c_strobe),
                            8'(mon_got.port_c_strobe));
                check_field("obf_pin", 8'(mon_want.obf_pin), 8'(mon_got.obf_pin));
                check_field("ibf_pin", 8'(mon_want.ibf_pin), 8'(mon_got.ibf_pin));
                check_field("intr_pin", 8'(mon_want.intr_pin), 8'(mon_got.intr_pin));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Clock, result-side stalls and watchdog
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("%0t: run stopped after %0d cycles", $time, CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        // reset-time view of the port state
        m_grp_a      = MODE_0;
        m_grp_b      = 1'b0;
        m_dir_a      = 8'hFF;
        m_dir_b      = 8'hFF;
        m_dir_c      = 8'hFF;
        m_lat_a      = 8'h00;
        m_lat_b      = 8'h00;
        m_lat_c      = 8'h00;
        m_drv_a      = 8'hFF;
        m_drv_b      = 8'hFF;
        m_drv_c      = 8'hFF;
        m_int_en     = 2'b00;
        m_obf        = 1'b0;
        m_ibf        = 1'b0;
        m_intr       = 1'b0;
        item_cnt     = 0;
        op_cnt       = '{default: 0};
        checked_cnt  = 0;
        mismatch_cnt = 0;
        mode0_cnt    = 0;
        mode2_cnt    = 0;
        odd_mode_cnt = 0;
        src_idle_pct = 6;
        snk_idle_pct = 88;

        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n     <= 1'b1;

        test_reset_state();
        test_mode0_ports();
        test_mode2_handshake();
        test_unsupported_modes();
        test_random_traffic(450);
        wait_results_drained();

        src_idle_pct = 88;
        snk_idle_pct = 6;
        test_random_traffic(450);
        wait_results_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_traffic(450);
        wait_results_drained();
        repeat (DRAIN_HOLD) @(posedge i_clk);

        $display("Sent %0d items (%0d reads, %0d writes, %0d strobe and %0d ack levels), "
                 , item_cnt, op_cnt[OP_READ], op_cnt[OP_WRITE], op_cnt[OP_STB],
                 op_cnt[OP_ACK]);
        $display("checked %0d results; mode words: %0d mode 0, %0d mode 2, %0d unsupported",
                 checked_cnt, mode0_cnt, mode2_cnt, odd_mode_cnt);
        if (mismatch_cnt == 0 && port_result_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
